// ===== hdl/pie_pkg.sv =====
// ----------------------------------------------------------------------------
// Probe response parser package
// Shared constants, codes and record types of the probe response parser.
// ----------------------------------------------------------------------------
package pie_pkg;

  // Default sizes, handed to the top level's parameters.
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int SSID_BYTES_DEF    = 32;
  localparam int MAX_FRAME_DEF     = 2048;

  // Frame layout and element codes.
  localparam logic [7:0] PROBE_RESP  = 8'h50;
  localparam int         IE_START    = 36;
  localparam int         BSSID_FIRST = 16;
  localparam int         BSSID_BYTES = 6;
  localparam logic [7:0] ID_SSID     = 8'd0;
  localparam logic [7:0] ID_RSN      = 8'd48;
  localparam logic [7:0] ID_VENDOR   = 8'd221;
  localparam logic [7:0] OUI_BYTE0   = 8'h00;
  localparam logic [7:0] OUI_BYTE1   = 8'h50;
  localparam logic [7:0] OUI_BYTE2   = 8'hF2;
  localparam logic [7:0] VENDOR_MIN  = 8'd4;

  // Width of the SSID carried in a frame record, and chunking of results.
  localparam int SSID_STORE  = 32;
  localparam int CHUNK_BYTES = 8;

  // Number of finished frame records held between the parser and the output.
  localparam int QUEUE_DEPTH = 2;

  // Reset value of the scanned channel.
  localparam logic [3:0] CHANNEL_RESET = 4'd1;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_NOT_PROBE  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    AUTH_OPEN = 2'd0,
    AUTH_WPA  = 2'd1,
    AUTH_WPA2 = 2'd2
  } auth_t;

  // One input transaction.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [47:0] bssid;
    logic [7:0]  ssid_len;
    logic [1:0]  auth_mode;
    logic [3:0]  channel;
    logic [1:0]  chunk_index;
    logic [63:0] ssid_chunk;
    logic        last_of_run;
  } out_item_t;

  // Summary of one finished frame, passed from the parser to the output side.
  typedef struct packed {
    status_t                           status;
    logic [3:0]                        entry_index;
    logic [47:0]                       bssid;
    logic [7:0]                        ssid_len;
    auth_t                             auth_mode;
    logic [3:0]                        channel;
    logic [SSID_STORE-1:0][7:0]        ssid;
  } rec_t;

  // Handshake between the record queue and the output side.
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

endpackage

// ===== hdl/pie_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel with a valid/ready handshake and a typed payload.
// ----------------------------------------------------------------------------
interface pie_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/pie_front.sv =====
// ----------------------------------------------------------------------------
// Probe response parser front end
// Takes frame bytes, walks the information elements and builds a frame record.
// ----------------------------------------------------------------------------
module pie_front import pie_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int SSID_BYTES    = SSID_BYTES_DEF,
  parameter int MAX_FRAME     = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pie_stream_if.sink  frame,
  input  logic [3:0]  scan_channel,
  input  logic        q_full,
  output logic        rec_push,
  output rec_t        rec
);

  localparam int PW = $clog2(MAX_FRAME + 1);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_DATA
  } phase_t;

  logic [PW-1:0] pos, pos_next;
  logic          too_long, too_long_next;
  logic [7:0]    first_byte, first_byte_next;
  logic [47:0]   bssid, bssid_next;
  phase_t        phase, phase_next;
  logic [7:0]    elem_id, elem_id_next;
  logic [7:0]    elem_len, elem_len_next;
  logic [7:0]    dcnt, dcnt_next;
  logic [2:0]    oui, oui_next;
  logic [7:0]    pending [SSID_BYTES];
  logic [7:0]    pending_next [SSID_BYTES];
  logic [7:0]    committed [SSID_BYTES];
  logic [7:0]    committed_next [SSID_BYTES];
  logic [7:0]    ssid_len, ssid_len_next;
  auth_t         auth, auth_next;
  logic [CW-1:0] entry_count, entry_count_next;

  logic          accept, take, restart, fin;
  logic [7:0]    fin_len, b;
  status_t       status;

  assign frame.ready = !q_full;
  assign accept      = frame.valid && frame.ready;
  assign take        = accept && !frame.payload.func;
  assign restart     = accept && (frame.payload.func || frame.payload.frame_end);
  assign b           = frame.payload.rx_byte;

  always_comb begin
    pos_next        = pos;
    too_long_next   = too_long;
    first_byte_next = first_byte;
    bssid_next      = bssid;
    phase_next      = phase;
    elem_id_next    = elem_id;
    elem_len_next   = elem_len;
    dcnt_next       = dcnt;
    oui_next        = oui;
    pending_next    = pending;
    committed_next  = committed;
    ssid_len_next   = ssid_len;
    auth_next       = auth;
    fin             = 1'b0;
    fin_len         = elem_len;

    if (take) begin
      if (too_long || pos >= PW'(MAX_FRAME)) begin
        too_long_next = 1'b1;
      end else begin
        if (pos == '0) begin
          first_byte_next = b;
        end
        if (pos >= PW'(BSSID_FIRST) && pos < PW'(BSSID_FIRST + BSSID_BYTES)) begin
          bssid_next = {bssid[39:0], b};
        end
        if (pos >= PW'(IE_START)) begin
          case (phase)
            PH_ID: begin
              elem_id_next = b;
              oui_next     = '0;
              phase_next   = PH_LEN;
            end
            PH_LEN: begin
              elem_len_next = b;
              dcnt_next     = '0;
              fin_len       = b;
              if (b == 8'd0) begin
                fin        = 1'b1;
                phase_next = PH_ID;
              end else begin
                phase_next = PH_DATA;
              end
            end
            PH_DATA: begin
              if (elem_id == ID_SSID) begin
                for (int i = 0; i < SSID_BYTES; i++) begin
                  if (dcnt == 8'(i)) pending_next[i] = b;
                end
              end
              if (dcnt == 8'd0 && b == OUI_BYTE0) oui_next[0] = 1'b1;
              if (dcnt == 8'd1 && b == OUI_BYTE1) oui_next[1] = 1'b1;
              if (dcnt == 8'd2 && b == OUI_BYTE2) oui_next[2] = 1'b1;
              dcnt_next = dcnt + 8'd1;
              if (dcnt + 8'd1 == elem_len) begin
                fin        = 1'b1;
                phase_next = PH_ID;
              end
            end
            default: begin
              phase_next = PH_ID;
            end
          endcase
        end
        pos_next = pos + PW'(1);
      end
    end

    // A complete element takes effect on its last byte.
    if (fin) begin
      if (elem_id == ID_SSID) begin
        ssid_len_next = fin_len;
        for (int i = 0; i < SSID_BYTES; i++) begin
          if (8'(i) < fin_len) committed_next[i] = pending_next[i];
        end
      end else if (elem_id == ID_RSN) begin
        auth_next = AUTH_WPA2;
      end else if (elem_id == ID_VENDOR) begin
        if (fin_len >= VENDOR_MIN && oui_next == 3'b111) auth_next = AUTH_WPA;
      end
    end
  end

  // Frame verdict, checked in priority order.
  always_comb begin
    if (!too_long_next && pos_next < PW'(IE_START)) begin
      status = ST_TOO_SHORT;
    end else if (first_byte_next != PROBE_RESP) begin
      status = ST_NOT_PROBE;
    end else if (entry_count >= CW'(TABLE_ENTRIES)) begin
      status = ST_TABLE_FULL;
    end else if (too_long_next) begin
      status = ST_TOO_LONG;
    end else begin
      status = ST_STORED;
    end
  end

  always_comb begin
    rec         = '0;
    rec.status  = status;
    rec.channel = scan_channel;
    if (status == ST_STORED) begin
      rec.entry_index = 4'(entry_count);
      rec.bssid       = bssid_next;
      rec.ssid_len    = ssid_len_next;
      rec.auth_mode   = auth_next;
      for (int i = 0; i < SSID_BYTES; i++) begin
        rec.ssid[i] = committed_next[i];
      end
    end
  end

  assign rec_push = take && frame.payload.frame_end;

  always_comb begin
    entry_count_next = entry_count;
    if (accept && frame.payload.func) begin
      entry_count_next = '0;
    end else if (rec_push && status == ST_STORED) begin
      entry_count_next = entry_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
    if (rst || restart) begin
      pos        <= '0;
      too_long   <= 1'b0;
      first_byte <= '0;
      bssid      <= '0;
      phase      <= PH_ID;
      elem_id    <= '0;
      elem_len   <= '0;
      dcnt       <= '0;
      oui        <= '0;
      ssid_len   <= '0;
      auth       <= AUTH_OPEN;
      for (int i = 0; i < SSID_BYTES; i++) begin
        pending[i]   <= '0;
        committed[i] <= '0;
      end
    end else if (take) begin
      pos        <= pos_next;
      too_long   <= too_long_next;
      first_byte <= first_byte_next;
      bssid      <= bssid_next;
      phase      <= phase_next;
      elem_id    <= elem_id_next;
      elem_len   <= elem_len_next;
      dcnt       <= dcnt_next;
      oui        <= oui_next;
      ssid_len   <= ssid_len_next;
      auth       <= auth_next;
      pending    <= pending_next;
      committed  <= committed_next;
    end
  end

endmodule

// ===== hdl/pie_queue.sv =====
// ----------------------------------------------------------------------------
// Probe response parser record queue
// Short first-in first-out store of finished frame records.
// ----------------------------------------------------------------------------
module pie_queue import pie_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  rec_t   push_rec,
  output logic   full,
  input  q_ctl_t ctl_in,
  output q_ctl_t ctl_out,
  output rec_t   head
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  rec_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          pop;

  assign pop           = ctl_in.pop && (count != '0);
  assign full          = (count == NW'(QUEUE_DEPTH));
  assign ctl_out.valid = (count != '0);
  assign ctl_out.pop   = pop;
  assign head          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

endmodule

// ===== hdl/pie_back.sv =====
// ----------------------------------------------------------------------------
// Probe response parser output stage
// Turns frame records into result transactions through an output register.
// ----------------------------------------------------------------------------
module pie_back import pie_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  rec_t         head,
  input  q_ctl_t       q_stat,
  output q_ctl_t       q_req,
  pie_stream_if.source result
);

  logic      out_valid;
  out_item_t out_item;
  logic [1:0] chunk;
  logic      load, last;

  assign load = q_stat.valid && (!out_valid || result.ready);
  assign last = (head.status != ST_STORED) || (chunk == 2'd3);

  assign q_req.valid = 1'b0;
  assign q_req.pop   = load && last;

  assign result.valid   = out_valid;
  assign result.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      chunk     <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      chunk     <= last ? 2'd0 : chunk + 2'd1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_item.status      <= head.status;
      out_item.entry_index <= head.entry_index;
      out_item.bssid       <= head.bssid;
      out_item.ssid_len    <= head.ssid_len;
      out_item.auth_mode   <= head.auth_mode;
      out_item.channel     <= head.channel;
      out_item.chunk_index <= chunk;
      out_item.ssid_chunk  <= head.ssid[{chunk, 3'b000} +: CHUNK_BYTES];
      out_item.last_of_run <= last;
    end
  end

endmodule

// ===== hdl/probe_response_ie_parser.sv =====
// ----------------------------------------------------------------------------
// Probe response information element parser
// Parses received probe response frames and reports scan table entries.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per clock cycle on the frame channel, with
// no gaps needed between frames. It checks the frame type, captures the BSSID,
// and walks the information elements, picking up the SSID and the security
// mode as each element completes. At the byte that ends a frame, a record of
// the frame goes into a queue of two records. The output side turns a stored
// frame into four result transactions (eight SSID bytes each, in chunk order)
// and a rejected frame into one status transaction, one transaction per cycle
// while the result channel is ready. The frame channel stalls only when the
// record queue is full, so with a result channel that keeps up the parser
// sustains one byte per cycle. A func transaction starts a new scan: it clears
// the entry count and drops any partly received frame. The scan channel
// register may be written only while no frame is in progress and no results
// are pending; it is accepted in any cycle.
// ----------------------------------------------------------------------------
module probe_response_ie_parser import pie_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int SSID_BYTES    = SSID_BYTES_DEF,
  parameter int MAX_FRAME     = MAX_FRAME_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pie_stream_if.sink   frame,
  pie_stream_if.source result,
  pie_stream_if.sink   cfg
);

  // Scanned channel, recorded into every frame record.
  logic [3:0] scan_channel;

  // Front end to queue.
  logic   q_push;
  logic   q_full;
  rec_t   q_in_rec;

  // Queue to output stage.
  rec_t   q_head;
  q_ctl_t q_stat;
  q_ctl_t q_req;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_channel <= CHANNEL_RESET;
    end else if (cfg.valid) begin
      scan_channel <= cfg.payload;
    end
  end

  // The front end parses bytes and decides the fate of each frame.
  pie_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SSID_BYTES    (SSID_BYTES),
    .MAX_FRAME     (MAX_FRAME)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .scan_channel (scan_channel),
    .q_full       (q_full),
    .rec_push     (q_push),
    .rec          (q_in_rec)
  );

  // The queue lets the parser run ahead while results are drained.
  pie_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_in_rec),
    .full     (q_full),
    .ctl_in   (q_req),
    .ctl_out  (q_stat),
    .head     (q_head)
  );

  // The output stage emits the results of each record.
  pie_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .q_stat (q_stat),
    .q_req  (q_req),
    .result (result)
  );

  // A record is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("frame record pushed into a full queue");

  // A rejected frame gives a single transaction that closes its run.
  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.status != ST_STORED
      |-> result.payload.last_of_run && result.payload.chunk_index == 2'd0)
    else $error("status transaction is not a single closing transaction");

  // A stored frame closes its run exactly on its last chunk.
  a_last_chunk: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.status == ST_STORED
      |-> result.payload.last_of_run == (result.payload.chunk_index == 2'd3))
    else $error("last_of_run does not match the final chunk");

  // Chunks of one stored frame follow each other without a gap.
  a_chunk_order: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !result.payload.last_of_run
      |=> result.valid
          && result.payload.chunk_index == $past(result.payload.chunk_index) + 2'd1)
    else $error("SSID chunks out of order");

endmodule
